@@ hdl/latg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// latg_pkg: shared types and constants of the toroidal life grid
// Beat layouts, request and register codes, controller states, the
// controller/datapath command and status bundles and the B3/S23 cell rule.
// ----------------------------------------------------------------------------
package latg_pkg;

   // default grid capacity
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 128;

   // size registers
   localparam int ROWS_CFG_W  = 7;
   localparam int COLS_CFG_W  = 8;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;
   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd30;
   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd90;

   // rule constants
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_STEP  = 2'd2
   } req_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] row_index;
      logic [6:0] col_index;
      logic       cell_in;
   } req_beat_type;

   typedef struct packed {
      logic cell_out;
      logic range_error;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_RD_WAIT,
      ST_WR_MOD,
      ST_GEN_PREV,
      ST_GEN_CUR,
      ST_GEN_ROW,
      ST_FINISH
   } ctrl_state_type;

   // grid read address sources
   typedef enum logic [2:0] {
      RD_REQ,
      RD_LAST,
      RD_ZERO,
      RD_ONE,
      RD_AHEAD
   } rd_sel_type;

   // grid write sources
   typedef enum logic [1:0] {
      WR_CLEAR,
      WR_CELL,
      WR_GEN
   } wr_sel_type;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       load_prev;
      logic       load_cur;
      logic       gen_shift;
      logic       cnt_clear;
      logic       cnt_inc;
      logic       load_cell;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] req_kind;
      logic       range_err;
      logic       clear_last;
      logic       gen_last;
      logic       rsp_free;
   } dp_status_type;

   // B3/S23: birth on three neighbors, survival on two or three
   function automatic logic life_rule(input logic [7:0] nbrs, input logic self_bit);
      logic [3:0] total;
      total = '0;
      for (int i = 0; i < 8; i++) begin
         total = total + 4'(nbrs[i]);
      end
      if (total == BIRTH_COUNT) begin
         return 1'b1;
      end else if (total == SURVIVE_COUNT) begin
         return self_bit;
      end
      return 1'b0;
   endfunction

endpackage
`default_nettype wire

@@ hdl/latg_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// latg_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module latg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hdl/latg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// latg_ctrl: request sequencer
// Runs the clearing pass, single-cell read and write, and the row-by-row
// generation walk, and issues datapath commands.
// ----------------------------------------------------------------------------
module latg_ctrl
   import latg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output dp_cmd_type         cmd,
   input  wire dp_status_type sts
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.req_kind) inside
               REQ_READ:  state_in = sts.range_err ? ST_FINISH : ST_RD_WAIT;
               REQ_WRITE: state_in = sts.range_err ? ST_FINISH : ST_WR_MOD;
               REQ_STEP:  state_in = ST_GEN_PREV;
               default:   state_in = ST_FINISH;
            endcase
         end
         ST_RD_WAIT:  state_in = ST_FINISH;
         ST_WR_MOD:   state_in = ST_FINISH;
         ST_GEN_PREV: state_in = ST_GEN_CUR;
         ST_GEN_CUR:  state_in = ST_GEN_ROW;
         ST_GEN_ROW: begin
            if (sts.gen_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_REQ;
      cmd.wr_sel = WR_CLEAR;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_CLEAR;
            cmd.cnt_clear = sts.clear_last;
            cmd.cnt_inc   = !sts.clear_last;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            unique case (sts.req_kind) inside
               REQ_READ, REQ_WRITE: begin
                  cmd.rd_en  = !sts.range_err;
                  cmd.rd_sel = RD_REQ;
               end
               REQ_STEP: begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_LAST;
               end
               default: begin
                  cmd.rd_en = 1'b0;
               end
            endcase
         end
         ST_RD_WAIT: begin
            cmd.load_cell = 1'b1;
         end
         ST_WR_MOD: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_CELL;
         end
         ST_GEN_PREV: begin
            cmd.load_prev = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_ZERO;
         end
         ST_GEN_CUR: begin
            cmd.load_cur  = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_ONE;
            cmd.cnt_clear = 1'b1;
         end
         ST_GEN_ROW: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_GEN;
            cmd.gen_shift = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_AHEAD;
            cmd.cnt_inc   = !sts.gen_last;
         end
         ST_FINISH: begin
            cmd.rsp_load = sts.rsp_free;
         end
         default: begin
            cmd.rsp_load = 1'b0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // a result never overwrites one still waiting
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("result loaded while output beat still pending");

   // the row walk only runs on a loaded window
   a_window_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN_ROW) |->
         ($past(state_ff) == ST_GEN_CUR) || ($past(state_ff) == ST_GEN_ROW))
      else $error("row walk entered without window load");

   // a captured request is decoded on the next cycle
   a_capture_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_DECODE) && !req_ready)
      else $error("captured request not decoded");

endmodule
`default_nettype wire

@@ hdl/latg_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// latg_datapath: grid datapath
// Size registers, request hold, three-row window and rule evaluation,
// grid memory addressing and the output register.
// ----------------------------------------------------------------------------
module latg_datapath
   import latg_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire req_beat_type                req_data,
   output rsp_beat_type                     rsp_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic                        csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_wdata,
   input  wire dp_cmd_type                  cmd,
   output dp_status_type                    sts,
   output logic                             mem_wr_en,
   output logic [$clog2(MAX_ROWS)-1:0]      mem_wr_addr,
   output logic [MAX_COLS-1:0]              mem_wr_data,
   output logic                             mem_rd_en,
   output logic [$clog2(MAX_ROWS)-1:0]      mem_rd_addr,
   input  wire logic [MAX_COLS-1:0]         mem_rd_data
);

   localparam int RAW   = $clog2(MAX_ROWS);
   localparam int CAW   = $clog2(MAX_COLS);
   localparam int RCNTW = $clog2(MAX_ROWS + 1) + 1;
   localparam int CCNTW = $clog2(MAX_COLS + 1) + 1;
   localparam int RW    = (RCNTW > ROWS_CFG_W) ? RCNTW : ROWS_CFG_W;
   localparam int CW    = (CCNTW > COLS_CFG_W) ? CCNTW : COLS_CFG_W;

   req_beat_type            req_ff, req_in;
   logic [ROWS_CFG_W-1:0]   rows_cfg_ff, rows_cfg_in;
   logic [COLS_CFG_W-1:0]   cols_cfg_ff, cols_cfg_in;
   logic [RAW-1:0]          row_ff, row_in;
   logic [MAX_COLS-1:0]     prev_ff, prev_in;
   logic [MAX_COLS-1:0]     cur_ff, cur_in;
   logic [MAX_COLS-1:0]     first_ff, first_in;
   logic                    cell_ff, cell_in_bit;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_beat_type            rsp_data_ff, rsp_data_in;

   logic [RW-1:0]           eff_rows;
   logic [CW-1:0]           eff_cols;
   logic [RW-1:0]           last_row;
   logic [RW-1:0]           ahead_row;
   logic [CAW-1:0]          last_col;
   logic [CAW-1:0]          col_addr;
   logic                    range_err;
   logic                    gen_last;
   logic                    kind_rw;
   logic [MAX_COLS-1:0]     next_src;
   logic [MAX_COLS-1:0]     row_mod;
   logic [MAX_COLS-1:0]     new_row;

   // clamp the sizes in use to one through capacity
   always_comb begin
      if (rows_cfg_ff == '0) begin
         eff_rows = RW'(1);
      end else if (RW'(rows_cfg_ff) > RW'(MAX_ROWS)) begin
         eff_rows = RW'(MAX_ROWS);
      end else begin
         eff_rows = RW'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         eff_cols = CW'(1);
      end else if (CW'(cols_cfg_ff) > CW'(MAX_COLS)) begin
         eff_cols = CW'(MAX_COLS);
      end else begin
         eff_cols = CW'(cols_cfg_ff);
      end
   end

   assign last_row  = eff_rows - RW'(1);
   assign last_col  = CAW'(eff_cols - CW'(1));
   assign ahead_row = RW'(row_ff) + RW'(2);
   assign col_addr  = CAW'(req_ff.col_index);
   assign range_err = (RW'(req_ff.row_index) >= eff_rows) ||
                      (CW'(req_ff.col_index) >= eff_cols);
   assign gen_last  = (RW'(row_ff) == last_row);
   assign kind_rw   = (req_ff.req_type == REQ_READ) || (req_ff.req_type == REQ_WRITE);

   // status to the sequencer
   always_comb begin
      sts            = '0;
      sts.req_kind   = req_ff.req_type;
      sts.range_err  = range_err;
      sts.clear_last = (row_ff == RAW'(MAX_ROWS - 1));
      sts.gen_last   = gen_last;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // size register writes
   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROWS: rows_cfg_in = csr_wdata[ROWS_CFG_W-1:0];
            CSR_COLS: cols_cfg_in = csr_wdata[COLS_CFG_W-1:0];
            default:  rows_cfg_in = rows_cfg_ff;
         endcase
      end
   end

   // grid read address
   always_comb begin
      mem_rd_en = cmd.rd_en;
      unique case (cmd.rd_sel)
         RD_REQ:   mem_rd_addr = RAW'(req_ff.row_index);
         RD_LAST:  mem_rd_addr = RAW'(last_row);
         RD_ZERO:  mem_rd_addr = '0;
         RD_ONE:   mem_rd_addr = (RW'(1) < eff_rows) ? RAW'(1) : '0;
         RD_AHEAD: mem_rd_addr = (ahead_row < eff_rows) ? RAW'(ahead_row) : '0;
         default:  mem_rd_addr = '0;
      endcase
   end

   // merge one cell into the row read back
   always_comb begin
      row_mod           = mem_rd_data;
      row_mod[col_addr] = req_ff.cell_in;
   end

   // below neighbor of the last row is the saved original first row
   assign next_src = gen_last ? first_ff : mem_rd_data;

   // evaluate one row of the next generation, wrapping at the column in use
   always_comb begin
      logic [MAX_COLS-1:0] p_l, c_l, n_l, p_r, c_r, n_r;
      logic [7:0]          nbrs;
      logic                at_end;
      p_l = {prev_ff[MAX_COLS-2:0], prev_ff[last_col]};
      c_l = {cur_ff[MAX_COLS-2:0], cur_ff[last_col]};
      n_l = {next_src[MAX_COLS-2:0], next_src[last_col]};
      p_r = {prev_ff[0], prev_ff[MAX_COLS-1:1]};
      c_r = {cur_ff[0], cur_ff[MAX_COLS-1:1]};
      n_r = {next_src[0], next_src[MAX_COLS-1:1]};
      new_row = cur_ff;
      for (int c = 0; c < MAX_COLS; c++) begin
         at_end = (CAW'(c) == last_col);
         nbrs = {p_l[c], prev_ff[c], at_end ? prev_ff[0] : p_r[c],
                 c_l[c],             at_end ? cur_ff[0]  : c_r[c],
                 n_l[c], next_src[c], at_end ? next_src[0] : n_r[c]};
         if (CW'(c) < eff_cols) begin
            new_row[c] = life_rule(nbrs, cur_ff[c]);
         end
      end
   end

   // grid write port
   always_comb begin
      mem_wr_en = cmd.wr_en;
      unique case (cmd.wr_sel)
         WR_CLEAR: begin
            mem_wr_addr = row_ff;
            mem_wr_data = '0;
         end
         WR_CELL: begin
            mem_wr_addr = RAW'(req_ff.row_index);
            mem_wr_data = row_mod;
         end
         WR_GEN: begin
            mem_wr_addr = row_ff;
            mem_wr_data = new_row;
         end
         default: begin
            mem_wr_addr = row_ff;
            mem_wr_data = '0;
         end
      endcase
   end

   // request hold, window shift, row counter and read result
   always_comb begin
      req_in      = cmd.capture ? req_data : req_ff;
      prev_in     = prev_ff;
      cur_in      = cur_ff;
      first_in    = first_ff;
      row_in      = row_ff;
      cell_in_bit = cmd.load_cell ? mem_rd_data[col_addr] : cell_ff;
      if (cmd.load_prev) begin
         prev_in = mem_rd_data;
      end
      if (cmd.load_cur) begin
         cur_in   = mem_rd_data;
         first_in = mem_rd_data;
      end
      if (cmd.gen_shift) begin
         prev_in = cur_ff;
         cur_in  = next_src;
      end
      if (cmd.cnt_clear) begin
         row_in = '0;
      end else if (cmd.cnt_inc) begin
         row_in = row_ff + RAW'(1);
      end
   end

   // output beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.cell_out     = (req_ff.req_type == REQ_READ) && !range_err && cell_ff;
         rsp_data_in.range_error  = kind_rw && range_err;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff  <= ROWS_RESET;
         cols_cfg_ff  <= COLS_RESET;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      first_ff    <= first_in;
      cell_ff     <= cell_in_bit;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an out-of-range write leaves the grid alone
   a_no_bad_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && (cmd.wr_sel == WR_CELL)) |-> !range_err)
      else $error("cell write issued with coordinate out of range");

   // generation writes stay inside the rows in use
   a_gen_in_rows: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && (cmd.wr_sel == WR_GEN)) |-> (RW'(row_ff) < eff_rows))
      else $error("generation row written outside rows in use");

   // an advance answers with an all-zero beat
   a_step_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && (req_ff.req_type == REQ_STEP)) |=> (rsp_data_ff == '0))
      else $error("advance result not zero");

endmodule
`default_nettype wire

@@ hdl/life_automaton_toroidal_grid.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_automaton_toroidal_grid: B3/S23 life grid on a torus
// Holds a grid of one-bit cells in a row-wide RAM; writes or reads one cell,
// or advances the region in use by one generation with wrap in both axes.
//
//   channel   ports                             handshake
//   request   req_valid req_ready req_data      valid/ready
//   result    rsp_valid rsp_ready rsp_data      valid/ready
//   config    csr_write_en csr_index csr_wdata  write enable, no wait
//
// One request is in work at a time; its result beat is registered, so the
// next request is taken while that beat waits. Read and write read the row,
// then select the bit, or merge the cell and write the row back, before the
// result beat. Out-of-range or unused request types skip the row access.
// Advance walks the rows in use, one grid row per cycle through the single
// RAM read port. After reset a clearing pass writes MAX_ROWS rows of zeros,
// one per cycle, before the first request is taken. A stalled result only
// holds the block once the next request has finished.
// ----------------------------------------------------------------------------
module life_automaton_toroidal_grid
   import latg_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_beat_type           req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_beat_type                rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int RAW = $clog2(MAX_ROWS);

   dp_cmd_type          cmd;
   dp_status_type       sts;
   logic                mem_wr_en;
   logic [RAW-1:0]      mem_wr_addr;
   logic [MAX_COLS-1:0] mem_wr_data;
   logic                mem_rd_en;
   logic [RAW-1:0]      mem_rd_addr;
   logic [MAX_COLS-1:0] mem_rd_data;

   // sequencer
   latg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath
   latg_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .sts          (sts),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   // grid store, one row per word
   latg_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the toroidal life grid
// Drives cell writes, cell reads and generation steps over valid/ready with
// random gaps and result stalls, and resizes the grid between phases.
// A grid tracker predicts each result beat from its own copy of the cells
// and the size registers, and checks every beat that comes back.
// ----------------------------------------------------------------------------
module tb_top;
   import latg_pkg::*;

   // request code the block must treat as a no-op
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 80;
   localparam int SETTLE_CYCLES = DEF_MAX_ROWS + 16;

   // Tracks grid contents and size, queues the result each request must give
   class grid_tracker;
      bit [DEF_MAX_COLS-1:0] cells [DEF_MAX_ROWS];
      bit [ROWS_CFG_W-1:0] rows_reg;
      bit [COLS_CFG_W-1:0] cols_reg;
      rsp_beat_type expected_replies [$];
      int mismatches;

      function new();
         foreach (cells[r]) cells[r] = '0;
         rows_reg = ROWS_RESET;
         cols_reg = COLS_RESET;
         mismatches = 0;
      endfunction

      function void set_size(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_ROWS) begin
            rows_reg = value[ROWS_CFG_W-1:0];
         end else begin
            cols_reg = value[COLS_CFG_W-1:0];
         end
      endfunction

      // clamp the size registers to what the grid can hold
      function int rows_now();
         if (rows_reg == 0) return 1;
         if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
         return int'(rows_reg);
      endfunction

      function int cols_now();
         if (cols_reg == 0) return 1;
         if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
         return int'(cols_reg);
      endfunction

      // B3/S23 on the torus; cells outside the region in use hold
      function void next_generation();
         bit [DEF_MAX_COLS-1:0] fresh [DEF_MAX_ROWS];
         int nr;
         int nc;
         int total;
         nr = rows_now();
         nc = cols_now();
         fresh = cells;
         for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
               total = 0;
               // tiny sizes may count one cell several times, as the wrap dictates
               for (int dr = -1; dr <= 1; dr++) begin
                  for (int dc = -1; dc <= 1; dc++) begin
                     if (dr != 0 || dc != 0) begin
                        total += cells[(r + nr + dr) % nr][(c + nc + dc) % nc];
                     end
                  end
               end
               if (total == BIRTH_COUNT) begin
                  fresh[r][c] = 1'b1;
               end else if (total != SURVIVE_COUNT) begin
                  fresh[r][c] = 1'b0;
               end
            end
         end
         cells = fresh;
      endfunction

      // apply one accepted request beat and queue its result
      function void note_request(req_beat_type beat);
         rsp_beat_type reply;
         reply = '0;
         case (beat.req_type)
            REQ_WRITE, REQ_READ: begin
               if (beat.row_index >= rows_now() || beat.col_index >= cols_now()) begin
                  reply.range_error = 1'b1;
               end else if (beat.req_type == REQ_WRITE) begin
                  cells[beat.row_index][beat.col_index] = beat.cell_in;
               end else begin
                  reply.cell_out = cells[beat.row_index][beat.col_index];
               end
            end
            REQ_STEP: begin
               next_generation();
            end
            default: begin
            end
         endcase
         expected_replies.push_back(reply);
      endfunction

      // compare one result beat with the oldest pending result
      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (expected_replies.size() == 0) begin
            $error("result beat with no request pending: cell_out %0b range_error %0b",
                   got.cell_out, got.range_error);
            mismatches++;
            return;
         end
         want = expected_replies.pop_front();
         if (got.cell_out !== want.cell_out) begin
            $error("cell_out: expected %0b, got %0b", want.cell_out, got.cell_out);
            mismatches++;
         end
         if (got.range_error !== want.range_error) begin
            $error("range_error: expected %0b, got %0b", want.range_error, got.range_error);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_beat_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_beat_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   grid_tracker tracker = new();
   bit steady = 1'b0;
   int holds_asked = 0;

   always #4 clock = ~clock;

   life_automaton_toroidal_grid dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Take result beats; stall at random, or hold off for a long stretch on request
   initial begin : result_side
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            tracker.check_result(rsp_data);
         end
         if (holds_seen != holds_asked) begin
            holds_seen = holds_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 19);
         end
      end
   end

   // Offer one request beat after a random gap; hold it until accepted
   task automatic send_request(input req_beat_type beat);
      while (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do begin
         @(posedge clock);
      end while (!req_ready);
      tracker.note_request(beat);
   endtask

   task automatic cell_op(input logic [1:0] kind, input int row, input int col,
                          input bit value);
      req_beat_type beat;
      beat.req_type = kind;
      beat.row_index = row[5:0];
      beat.col_index = col[6:0];
      beat.cell_in = value;
      send_request(beat);
   endtask

   // Drop valid and wait for every pending result, then let the block settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.expected_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // Write both size registers on back-to-back edges
   task automatic set_grid_size(input logic [CSR_DATA_W-1:0] rows_value,
                                input logic [CSR_DATA_W-1:0] cols_value);
      csr_write_en <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows_value;
      @(posedge clock);
      tracker.set_size(CSR_ROWS, rows_value);
      csr_index <= CSR_COLS;
      csr_wdata <= cols_value;
      @(posedge clock);
      tracker.set_size(CSR_COLS, cols_value);
      csr_write_en <= 1'b0;
   endtask

   // index close to either side of the wrap seam
   function automatic int near_edge(int span);
      int reach;
      reach = (span < 4) ? span : 4;
      if ($urandom_range(1)) return $urandom_range(reach - 1);
      return span - 1 - $urandom_range(reach - 1);
   endfunction

   // Mostly writes and reads packed around the wrap corner, so steps see life
   function automatic req_beat_type random_request();
      req_beat_type beat;
      int pick;
      int place;
      int nr;
      int nc;
      int row;
      int col;
      nr = tracker.rows_now();
      nc = tracker.cols_now();
      row = $urandom_range(63);
      col = $urandom_range(127);
      beat.cell_in = ($urandom_range(99) < 65);
      pick = $urandom_range(99);
      if (pick < 42) beat.req_type = REQ_WRITE;
      else if (pick < 75) beat.req_type = REQ_READ;
      else if (pick < 94) beat.req_type = REQ_STEP;
      else beat.req_type = REQ_UNUSED;
      if (beat.req_type == REQ_WRITE || beat.req_type == REQ_READ) begin
         place = $urandom_range(99);
         if (place < 12 && (nr < DEF_MAX_ROWS || nc < DEF_MAX_COLS)) begin
            if (nc == DEF_MAX_COLS || (nr < DEF_MAX_ROWS && $urandom_range(1))) begin
               row = $urandom_range(63, nr);
            end else begin
               col = $urandom_range(127, nc);
            end
         end else if (place < 45) begin
            row = $urandom_range(nr - 1);
            col = $urandom_range(nc - 1);
         end else begin
            row = near_edge(nr);
            col = near_edge(nc);
         end
      end
      beat.row_index = row[5:0];
      beat.col_index = col[6:0];
      return beat;
   endfunction

   initial begin : stimulus
      int rows_plan [$];
      int cols_plan [$];
      rows_plan = '{64, 0, 255, 1, 2, 2, 3, 5, 12, 127, 0, 0};
      cols_plan = '{128, 0, 255, 2, 1, 2, 3, 8, 17, 200, 0, 0};
      rows_plan[10] = $urandom_range(1, 64);
      cols_plan[10] = $urandom_range(1, 128);
      rows_plan[11] = $urandom_range(1, 64);
      cols_plan[11] = $urandom_range(1, 128);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed checks at the reset size (30 x 90)
      cell_op(REQ_READ, 0, 0, 1'b0);
      cell_op(REQ_WRITE, 29, 89, 1'b1);
      cell_op(REQ_READ, 29, 89, 1'b0);
      cell_op(REQ_WRITE, 30, 0, 1'b1);
      cell_op(REQ_WRITE, 0, 90, 1'b1);
      cell_op(REQ_READ, 63, 127, 1'b1);
      cell_op(REQ_UNUSED, 63, 127, 1'b1);
      cell_op(REQ_WRITE, 29, 89, 1'b0);
      // blinker straddling the column seam flips across the row seam
      cell_op(REQ_WRITE, 0, 89, 1'b1);
      cell_op(REQ_WRITE, 0, 0, 1'b1);
      cell_op(REQ_WRITE, 0, 1, 1'b1);
      cell_op(REQ_STEP, 0, 0, 1'b0);
      cell_op(REQ_READ, 29, 0, 1'b0);
      cell_op(REQ_READ, 0, 0, 1'b0);
      cell_op(REQ_READ, 1, 0, 1'b0);
      cell_op(REQ_READ, 0, 89, 1'b0);
      cell_op(REQ_STEP, 63, 127, 1'b1);
      cell_op(REQ_READ, 0, 89, 1'b0);
      cell_op(REQ_READ, 0, 1, 1'b0);
      // a lone cell dies
      cell_op(REQ_WRITE, 10, 40, 1'b1);
      cell_op(REQ_STEP, 0, 0, 1'b0);
      cell_op(REQ_READ, 10, 40, 1'b0);

      // random phases, one grid size each
      foreach (rows_plan[p]) begin
         wait_drained();
         set_grid_size(rows_plan[p][CSR_DATA_W-1:0], cols_plan[p][CSR_DATA_W-1:0]);
         steady = (p == 5);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 2 && n == 10) begin
               holds_asked++;
            end
            if (p == 6 && n == 40) begin
               wait_drained();
            end
            send_request(random_request());
         end
      end
      steady = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Guard against a hang
   initial begin : watchdog
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
